/* sv/bsfs_pkg.sv */
// bsfs_pkg: shared constants, widths and types for the best small fraction search.
// Used by bsfs_ctrl, bsfs_datapath, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package bsfs_pkg;

  // Largest numerator and denominator tried
  localparam int TERM_MAX       = 127;
  // Fraction bits of the incoming gain
  localparam int GAIN_FRAC_BITS = 16;
  // Port widths
  localparam int GAIN_W         = 24;
  localparam int OUT_W          = 7;

  // Counter width: holds TERM_MAX, never narrower than the result ports
  localparam int TERM_W = $clog2(TERM_MAX + 1);
  localparam int CNT_W  = (TERM_W > OUT_W) ? TERM_W : OUT_W;
  // Scaled distance |n*2^F - d*g|, bounded by TERM_MAX * 2^GAIN_W
  localparam int D_W    = GAIN_W + TERM_W;
  // Cross products distance * denominator
  localparam int P_W    = D_W + CNT_W;

  localparam logic [CNT_W-1:0] TERM_MAX_C = CNT_W'(TERM_MAX);
  localparam logic [D_W-1:0]   SI_STEP    = D_W'(1) << GAIN_FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;     // capture gain, set up counters and best candidate
    logic issue;     // send current candidate down and advance counters
    logic load_out;  // copy best candidate into the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_cand; // counters sit on the final candidate
  } dp_sts_t;

endpackage

/* sv/bsfs_ctrl.sv */
// bsfs_ctrl: state machine that sequences the candidate scan and owns both handshakes.
// Depends on bsfs_pkg for the state and command/status types.
`timescale 1ns / 1ps

module bsfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bsfs_pkg::dp_sts_t sts,
  output bsfs_pkg::dp_cmd_t cmd
);

  bsfs_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // Output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsfs_pkg::ST_IDLE:   if (in_valid) state_nxt = bsfs_pkg::ST_SCAN;
      bsfs_pkg::ST_SCAN:   if (sts.last_cand) state_nxt = bsfs_pkg::ST_FLUSH;
      bsfs_pkg::ST_FLUSH:  state_nxt = bsfs_pkg::ST_FINISH;
      bsfs_pkg::ST_FINISH: if (out_free) state_nxt = bsfs_pkg::ST_IDLE;
      default:             state_nxt = bsfs_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      bsfs_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      bsfs_pkg::ST_SCAN:   cmd.issue    = 1'b1;
      bsfs_pkg::ST_FLUSH:  cmd          = '0;
      bsfs_pkg::ST_FINISH: cmd.load_out = out_free;
      default:             cmd          = '0;
    endcase
  end

  // Result valid flag: set on load, cleared when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsfs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/bsfs_datapath.sv */
// bsfs_datapath: candidate counters, distance stage, cross-multiply compare and best register.
// Depends on bsfs_pkg for widths, constants and command/status types.
`timescale 1ns / 1ps

module bsfs_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bsfs_pkg::dp_cmd_t                  cmd,
  input  logic signed [bsfs_pkg::GAIN_W-1:0] in_gain_fixed,
  output bsfs_pkg::dp_sts_t                  sts,
  output logic [bsfs_pkg::OUT_W-1:0]         out_numerator,
  output logic [bsfs_pkg::OUT_W-1:0]         out_denominator
);

  localparam int GAIN_W = bsfs_pkg::GAIN_W;
  localparam int CNT_W  = bsfs_pkg::CNT_W;
  localparam int D_W    = bsfs_pkg::D_W;
  localparam int P_W    = bsfs_pkg::P_W;
  localparam int OUT_W  = bsfs_pkg::OUT_W;

  logic [GAIN_W-1:0] gain_mag;
  logic [GAIN_W-1:0] g_r;
  logic [CNT_W-1:0]  i_r, j_r;
  logic [D_W-1:0]    si_r, jg_r;        // i*2^F and j*g, kept by accumulation
  logic [D_W-1:0]    cand_d;
  logic [D_W-1:0]    d1_r;
  logic [CNT_W-1:0]  i1_r, j1_r;
  logic              s1_vld_r;
  logic [CNT_W-1:0]  best_num_r, best_den_r, best_j_r;
  logic [D_W-1:0]    best_d_r;
  logic [P_W-1:0]    lhs, rhs;
  logic              closer;
  logic [OUT_W-1:0]  num_out_r, den_out_r;

  // Magnitude; the most negative code maps to 2^(GAIN_W-1)
  assign gain_mag = in_gain_fixed[GAIN_W-1] ? (~$unsigned(in_gain_fixed) + GAIN_W'(1))
                                            : $unsigned(in_gain_fixed);

  assign sts.last_cand = (i_r == bsfs_pkg::TERM_MAX_C) && (j_r == bsfs_pkg::TERM_MAX_C);

  // Distance of the current candidate, scaled by 2^F
  assign cand_d = (si_r >= jg_r) ? (si_r - jg_r) : (jg_r - si_r);

  // Candidate counters: denominator inner, numerator outer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      g_r  <= gain_mag;
      i_r  <= '0;
      j_r  <= CNT_W'(1);
      si_r <= '0;
      jg_r <= D_W'(gain_mag);
    end else if (cmd.issue) begin
      if (j_r == bsfs_pkg::TERM_MAX_C) begin
        j_r  <= CNT_W'(1);
        jg_r <= D_W'(g_r);
        i_r  <= i_r + CNT_W'(1);
        si_r <= si_r + bsfs_pkg::SI_STEP;
      end else begin
        j_r  <= j_r + CNT_W'(1);
        jg_r <= jg_r + D_W'(g_r);
      end
    end
  end

  // Stage 1: registered distance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      d1_r <= cand_d;
      i1_r <= i_r;
      j1_r <= j_r;
    end
  end

  // Stage 2: d/j < best_d/best_j by cross-multiplication
  assign lhs    = P_W'(d1_r) * P_W'(best_j_r);
  assign rhs    = P_W'(best_d_r) * P_W'(j1_r);
  assign closer = lhs < rhs;

  // Best candidate so far; starts at 0/TERM_MAX with the distance of 0/1
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_num_r <= '0;
      best_den_r <= bsfs_pkg::TERM_MAX_C;
      best_d_r   <= D_W'(gain_mag);
      best_j_r   <= CNT_W'(1);
    end else if (s1_vld_r && closer) begin
      best_num_r <= i1_r;
      best_den_r <= j1_r;
      best_d_r   <= d1_r;
      best_j_r   <= j1_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      num_out_r <= best_num_r[OUT_W-1:0];
      den_out_r <= best_den_r[OUT_W-1:0];
    end
  end

  assign out_numerator   = num_out_r;
  assign out_denominator = den_out_r;

endmodule

/* sv/best_small_fraction_search.sv */
// Best small fraction search: finds the fraction n/d (n, d <= 127, d >= 1) closest to |gain|.
// Gain is two's complement Q8.16 on in_gain_fixed; the most negative code counts as 128.0.
// Input channel: in_valid/in_stall/in_gain_fixed. A transaction completes on a rising edge
// with in_valid high and in_stall low. in_stall is low only while the block is idle.
// Output channel: out_valid/out_stall/out_numerator/out_denominator, from an output register;
// one result per input. Candidates are scanned numerator-major, then denominator, one per
// cycle through a counter pair, a distance register and a cross-multiply compare stage;
// a later candidate wins only if strictly closer, and a gain nearest zero gives 0/127.
// The scan is paced by the single compare unit, which sees one candidate a cycle; a new input
// is taken only once the last search is done. The block scans in ST_SCAN, drains the compare
// stage in ST_FLUSH and loads the output register, which shows the result, in ST_FINISH.
// While a result waits under out_stall, the block goes back to idle and takes the next input;
// that search finishes and then holds until the output register is free.
// Synchronous active-low reset on rst_n returns to idle with no result pending.
// Depends on bsfs_pkg, bsfs_ctrl and bsfs_datapath.
`timescale 1ns / 1ps

module best_small_fraction_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [bsfs_pkg::GAIN_W-1:0] in_gain_fixed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bsfs_pkg::OUT_W-1:0]         out_numerator,
  output logic [bsfs_pkg::OUT_W-1:0]         out_denominator
);

  bsfs_pkg::dp_cmd_t cmd;
  bsfs_pkg::dp_sts_t sts;

  // Sequencer and handshakes
  bsfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Counters, compare and result storage
  bsfs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_gain_fixed   (in_gain_fixed),
    .sts             (sts),
    .out_numerator   (out_numerator),
    .out_denominator (out_denominator)
  );

endmodule

/* sv/bsfs_checker.sv */
// bsfs_checker: port-level assertions for best_small_fraction_search, bound to the top level.
// Depends on bsfs_pkg for the term limit and port widths.
`timescale 1ns / 1ps

module bsfs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bsfs_pkg::OUT_W-1:0] out_numerator,
  input logic [bsfs_pkg::OUT_W-1:0] out_denominator
);

  localparam logic [bsfs_pkg::OUT_W-1:0] DEN_DEFAULT = bsfs_pkg::OUT_W'(bsfs_pkg::TERM_MAX);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_numerator) && $stable(out_denominator))
    else $error("stalled result changed or dropped");

  // Denominator is never zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_denominator != '0)
    else $error("zero denominator");

  // A zero numerator only comes from the default fraction
  a_zero_default: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_numerator == '0 |-> out_denominator == DEN_DEFAULT)
    else $error("zero numerator with non-default denominator");

  // After an input transaction the block is busy and no result appears at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !$rose(out_valid))
    else $error("block not busy after input transaction");

endmodule

bind best_small_fraction_search bsfs_checker u_bsfs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_numerator   (out_numerator),
  .out_denominator (out_denominator)
);

/* tb/tb_top.sv */
// tb_top: self-checking testbench for best_small_fraction_search (closest n/d to |gain|).
// Drives directed and random gains through the valid/stall input channel and checks each
// result against its known row or an exact search over all candidates; uses bsfs_pkg.
`timescale 1ns / 1ps

module tb_top;

  // Cycles from an input transaction until its result could still show up
  localparam int SEARCH_CYCLES     = bsfs_pkg::TERM_MAX * (bsfs_pkg::TERM_MAX + 1) + 3;
  localparam int N_DIRECTED        = 21;
  localparam int RANDOM_PER_PHASE  = 20;
  localparam int N_PHASES          = 4;

  typedef struct packed {
    logic [bsfs_pkg::OUT_W-1:0] num;
    logic [bsfs_pkg::OUT_W-1:0] den;
  } frac_t;

  // One directed gain; known set means the expected fraction is given in the row
  typedef struct packed {
    logic [bsfs_pkg::GAIN_W-1:0] gain;
    logic                        known;
    logic [bsfs_pkg::OUT_W-1:0]  num;
    logic [bsfs_pkg::OUT_W-1:0]  den;
  } gain_row_t;

  localparam gain_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{24'h000000, 1'b1, 7'd0,   7'd127},  // zero gives the default 0/127
    '{24'h000001, 1'b1, 7'd0,   7'd127},  // smallest positive stays at 0/127
    '{24'hFFFFFF, 1'b1, 7'd0,   7'd127},  // -1 lsb, magnitude 1 lsb
    '{24'h010000, 1'b1, 7'd1,   7'd1},
    '{24'hFF0000, 1'b1, 7'd1,   7'd1},    // -1.0
    '{24'h008000, 1'b1, 7'd1,   7'd2},
    '{24'h7FFFFF, 1'b1, 7'd127, 7'd1},    // largest positive
    '{24'h800000, 1'b1, 7'd127, 7'd1},    // most negative counts as 128.0
    '{24'h7E8000, 1'b1, 7'd126, 7'd1},    // 126.5: tie, earlier numerator kept
    '{24'h818000, 1'b1, 7'd126, 7'd1},    // -126.5: same tie
    '{24'h040000, 1'b1, 7'd4,   7'd1},    // 4/1 found before 8/2
    '{24'hC00000, 1'b1, 7'd64,  7'd1},    // -64.0
    '{24'h7F0000, 1'b1, 7'd127, 7'd1},
    '{24'h000100, 1'b0, 7'd0,   7'd0},    // near the 0 vs 1/127 boundary
    '{24'h000102, 1'b0, 7'd0,   7'd0},
    '{24'h000103, 1'b0, 7'd0,   7'd0},
    '{24'h00AAAB, 1'b0, 7'd0,   7'd0},
    '{24'h3243F7, 1'b0, 7'd0,   7'd0},
    '{24'h555555, 1'b0, 7'd0,   7'd0},
    '{24'hAAAAAA, 1'b0, 7'd0,   7'd0},
    '{24'h00FFFF, 1'b0, 7'd0,   7'd0}
  };

  // Sender/receiver idle percentages per random phase
  localparam int SEND_IDLE_PCT [N_PHASES] = '{0, 47, 0, 35};
  localparam int STALL_PCT     [N_PHASES] = '{0, 0, 47, 35};

  logic                        clk           = 1'b0;
  logic                        rst_n         = 1'b0;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic [bsfs_pkg::GAIN_W-1:0] in_gain_fixed = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic [bsfs_pkg::OUT_W-1:0]  out_numerator;
  logic [bsfs_pkg::OUT_W-1:0]  out_denominator;

  frac_t pending_fracs[$];
  frac_t want_frac;
  int    mismatch_count = 0;
  int    send_idle_pct  = 0;
  int    stall_pct      = 0;

  best_small_fraction_search u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_gain_fixed   (in_gain_fixed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_numerator   (out_numerator),
    .out_denominator (out_denominator)
  );

  always #5 clk = ~clk;

  // Exact search: |n*2^F - d*g| / d compared by cross-multiplication, first winner kept
  function automatic frac_t closest_fraction(input logic [bsfs_pkg::GAIN_W-1:0] raw);
    longint unsigned mag;
    longint unsigned best_dist;
    longint unsigned best_den;
    longint unsigned scaled_n;
    longint unsigned dg;
    longint unsigned cand_dist;
    frac_t           best;
    mag       = raw[bsfs_pkg::GAIN_W-1] ? ((64'd1 << bsfs_pkg::GAIN_W) - 64'(raw))
                                        : 64'(raw);
    best.num  = '0;
    best.den  = bsfs_pkg::OUT_W'(bsfs_pkg::TERM_MAX);
    best_dist = mag;  // distance of 0/1
    best_den  = 1;
    for (int n = 0; n <= bsfs_pkg::TERM_MAX; n++) begin
      scaled_n = 64'(n) << bsfs_pkg::GAIN_FRAC_BITS;
      for (int d = 1; d <= bsfs_pkg::TERM_MAX; d++) begin
        dg        = 64'(d) * mag;
        cand_dist = (scaled_n >= dg) ? (scaled_n - dg) : (dg - scaled_n);
        if (cand_dist * best_den < best_dist * 64'(d)) begin
          best_dist = cand_dist;
          best_den  = 64'(d);
          best.num  = bsfs_pkg::OUT_W'(n);
          best.den  = bsfs_pkg::OUT_W'(d);
        end
      end
    end
    return best;
  endfunction

  // Random gain: full range, below one, close to a random fraction, or whole numbers
  function automatic logic [bsfs_pkg::GAIN_W-1:0] random_gain();
    logic [bsfs_pkg::GAIN_W-1:0] gain;
    int unsigned                 n;
    int unsigned                 d;
    case ($urandom_range(3))
      0: gain = bsfs_pkg::GAIN_W'($urandom);
      1: gain = bsfs_pkg::GAIN_W'($urandom_range(65535));
      2: begin
        n    = $urandom_range(127);
        d    = $urandom_range(127, 1);
        gain = bsfs_pkg::GAIN_W'(((n << bsfs_pkg::GAIN_FRAC_BITS) / d)
                                 + $urandom_range(2)) - 1'b1;
      end
      default: gain = bsfs_pkg::GAIN_W'($urandom_range(255)) << bsfs_pkg::GAIN_FRAC_BITS;
    endcase
    if ($urandom_range(1))
      gain = -gain;
    return gain;
  endfunction

  // Offer one gain, hold it until accepted, then record the expected fraction
  task automatic send_gain(input logic [bsfs_pkg::GAIN_W-1:0] gain, input logic known,
                           input frac_t known_frac);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_gain_fixed <= gain;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_fracs.push_back(known ? known_frac : closest_fraction(gain));
  endtask

  // Hold the input channel quiet until every pending result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_fracs.size() != 0)
      @(posedge clk);
  endtask

  // Result side: random stall, compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_fracs.size() == 0) begin
        $error("result %0d/%0d with no transaction pending", out_numerator, out_denominator);
        mismatch_count++;
      end else begin
        want_frac = pending_fracs.pop_front();
        if (out_numerator !== want_frac.num) begin
          $error("numerator: expected %0d, got %0d", want_frac.num, out_numerator);
          mismatch_count++;
        end
        if (out_denominator !== want_frac.den) begin
          $error("denominator: expected %0d, got %0d", want_frac.den, out_denominator);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, drain, random phases, final wait
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_gain(DIRECTED_ROWS[i].gain, DIRECTED_ROWS[i].known,
                '{DIRECTED_ROWS[i].num, DIRECTED_ROWS[i].den});
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      stall_pct    <= STALL_PCT[p];
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        send_gain(random_gain(), 1'b0, '0);
    end

    wait_drained();
    repeat (SEARCH_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog, several times the slowest correct run
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/bsfs_pkg.sv
sv/bsfs_ctrl.sv
sv/bsfs_datapath.sv
sv/best_small_fraction_search.sv
sv/bsfs_checker.sv
tb/tb_top.sv
